FILE: rtl/ttcw_pkg.sv
// shared types, codes and constants of the terminal character writer
`timescale 1ns / 1ps
`default_nettype none

package ttcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 24;

	localparam int ROW_PORT_W  = 5;
	localparam int COL_PORT_W  = 7;
	localparam int ADDR_PORT_W = 11;
	localparam int MARGIN_W    = 5;
	localparam int CFG_IDX_W   = 1;

	localparam logic [7:0] CURSOR_BIT = 8'h80;
	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_HT    = 8'h09;
	localparam logic [7:0] PRINT_MIN  = 8'h20;
	localparam logic [7:0] PRINT_MAX  = 8'hFF;

	localparam logic [MARGIN_W-1:0] TOP_RESET    = 5'd0;
	localparam logic [MARGIN_W-1:0] BOTTOM_RESET = 5'd23;

	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 1'd1;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_IGNORE = 3'd0;
	localparam kind_t KIND_READ   = 3'd1;
	localparam kind_t KIND_PRINT  = 3'd2;
	localparam kind_t KIND_BS     = 3'd3;
	localparam kind_t KIND_TAB    = 3'd4;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data;
		logic [ADDR_PORT_W-1:0] addr;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/text_terminal_char_writer.sv
// Text terminal character writer, top level.
//
// Input queue: push with mode, rx_byte and read_address; taken when push is high and
// full is low. mode 0 processes a received byte (printable, backspace, tab, others
// ignored), mode 1 reads one cell of the ROWS x COLUMNS character store.
// Result register: one result per item, oldest first, valid while empty is low and taken
// with pop. It carries the cursor position, wrap_pending and the cell read.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 top margin, 1 bottom margin)
// and cfg_data; cfg_ready is always high. Write only while the block is idle.
// Each item is done one at a time by a sequencer around the single store ram: a read
// takes its cell; tab and backspace (not in column 0) unmark the cursor cell, move and
// mark the new one; a printable is stored and the next cell marked, but in the last
// column it keeps the mark and defers the wrap to the next printable; others only give
// a result. A wrap past the last line moves lines top + 1 to bottom one line up, one
// cell per cycle, and clears the bottom line (only that when bottom is not past top).
// A two entry input queue lets bytes arrive while one is in work. Reset: margins go
// to 0 and 23, then full stays high while a clearing pass writes the blank screen
// with the cursor at cell 0. A stalled result (pop low) holds its register; the
// sequencer then waits with the next result and the input queue fills and raises full.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_char_writer #(
	parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             mode,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic [ttcw_pkg::ADDR_PORT_W-1:0] read_address,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [ttcw_pkg::ROW_PORT_W-1:0]       cursor_row,
	output logic [ttcw_pkg::COL_PORT_W-1:0]       cursor_col,
	output logic                                  wrap_pending,
	output logic [7:0]                            cell_value,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ttcw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ttcw_pkg::MARGIN_W-1:0]    cfg_data
);
	import ttcw_pkg::*;

	logic [MARGIN_W-1:0] top_margin_q;
	logic [MARGIN_W-1:0] bottom_margin_q;
	logic                init_done;
	logic                head_valid;
	item_t               head;
	logic                deq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_margin_q    <= TOP_RESET;
			bottom_margin_q <= BOTTOM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOP: top_margin_q <= cfg_data;
				REG_BOTTOM: bottom_margin_q <= cfg_data;
				default: begin
					top_margin_q <= top_margin_q;
				end
			endcase
		end
	end

	ttcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.rx_byte     (rx_byte),
		.read_address(read_address),
		.init_done   (init_done),
		.head_valid  (head_valid),
		.head        (head),
		.deq         (deq)
	);

	ttcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.top_margin   (top_margin_q),
		.bottom_margin(bottom_margin_q),
		.head_valid   (head_valid),
		.head         (head),
		.deq          (deq),
		.init_done    (init_done),
		.pop          (pop),
		.empty        (empty),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.wrap_pending (wrap_pending),
		.cell_value   (cell_value)
	);

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(cursor_col) <= COLUMNS - 1))
		else $error("cursor column beyond last column");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(cursor_row) <= ROWS - 1))
		else $error("cursor row beyond last row");

	a_wrap_col: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && wrap_pending) |-> (32'(cursor_col) == COLUMNS - 1))
		else $error("pending wrap away from last column");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> full)
		else $error("input open during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: rtl/ttcw_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ttcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1920,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/ttcw_front.sv
// input side: classifies incoming items and holds them in a short queue
`timescale 1ns / 1ps
`default_nettype none

module ttcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              mode,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic [ttcw_pkg::ADDR_PORT_W-1:0]  read_address,
	input  wire logic                              init_done,
	output logic                                   head_valid,
	output ttcw_pkg::item_t                        head,
	input  wire logic                              deq
);
	import ttcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            in_item;
	item_t            q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             enq;
	logic             pop_head;

	always_comb begin
		in_item.data = rx_byte;
		in_item.addr = read_address;
		if (mode) begin
			in_item.kind = (32'(read_address) < CELLS) ? KIND_READ : KIND_IGNORE;
		end else if (rx_byte inside {[PRINT_MIN:PRINT_MAX]}) begin
			in_item.kind = KIND_PRINT;
		end else begin
			case (rx_byte)
				BYTE_BS: in_item.kind = KIND_BS;
				BYTE_HT: in_item.kind = KIND_TAB;
				default: in_item.kind = KIND_IGNORE;
			endcase
		end
	end

	// no items until the store has been swept clear
	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH)) || !init_done;
	assign enq        = push && !full;
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem[rd_ptr_q];
	assign pop_head   = deq && head_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_head) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !pop_head) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_head && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ttcw_back.sv
// execution side: cursor state, character store sequencer, scroll and result register
`timescale 1ns / 1ps
`default_nettype none

module ttcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [ttcw_pkg::MARGIN_W-1:0]    top_margin,
	input  wire logic [ttcw_pkg::MARGIN_W-1:0]    bottom_margin,
	input  wire logic                             head_valid,
	input  wire ttcw_pkg::item_t                  head,
	output logic                                  deq,
	output logic                                  init_done,
	input  wire logic                             pop,
	output logic                                  empty,
	output logic [ttcw_pkg::ROW_PORT_W-1:0]       cursor_row,
	output logic [ttcw_pkg::COL_PORT_W-1:0]       cursor_col,
	output logic                                  wrap_pending,
	output logic [7:0]                            cell_value
);
	import ttcw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_READ      = 4'd2;
	localparam logic [3:0] ST_UNMARK_RD = 4'd3;
	localparam logic [3:0] ST_UNMARK_WR = 4'd4;
	localparam logic [3:0] ST_MARK_RD   = 4'd5;
	localparam logic [3:0] ST_MARK_WR   = 4'd6;
	localparam logic [3:0] ST_PUT       = 4'd7;
	localparam logic [3:0] ST_SCR_SET   = 4'd8;
	localparam logic [3:0] ST_SCR_COPY  = 4'd9;
	localparam logic [3:0] ST_SCR_DRAIN = 4'd10;
	localparam logic [3:0] ST_SCR_CLEAR = 4'd11;
	localparam logic [3:0] ST_RESULT    = 4'd12;

	logic [3:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              defer_q;
	kind_t             kind_q;
	logic [7:0]        data_q;
	logic [7:0]        cell_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] last_q;
	logic [ADDR_W-1:0] dst_q;
	logic              rv_q;
	logic [COL_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_wrap_q;
	logic [7:0]        out_cell_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	logic [ADDR_W-1:0] cur_idx;
	logic [COL_W:0]    tab_sum;
	logic [COL_W:0]    tab_round;
	logic [COL_W-1:0]  tab_col;
	logic [ROW_W-1:0]  top_c;
	logic [ROW_W-1:0]  bot_c;
	logic [ADDR_W-1:0] bot_base;
	logic              out_free;
	logic              out_load;

	ttcw_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cur_idx   = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
	assign tab_sum   = {1'b0, col_q} + (COL_W + 1)'(8);
	assign tab_round = tab_sum & ~(COL_W + 1)'(7);
	assign tab_col   = (tab_round > (COL_W + 1)'(COLUMNS - 1)) ? LAST_COL : tab_round[COL_W-1:0];
	assign top_c     = (32'(top_margin) > ROWS - 1) ? LAST_ROW : ROW_W'(top_margin);
	assign bot_c     = (32'(bottom_margin) > ROWS - 1) ? LAST_ROW : ROW_W'(bottom_margin);
	assign bot_base  = ADDR_W'(bot_c) * COLS_A;
	assign out_free  = !out_valid_q || pop;
	assign out_load  = (state_q == ST_RESULT) && out_free;

	assign deq       = (state_q == ST_IDLE) && head_valid;
	assign init_done = (state_q != ST_CLEAR);

	always_comb begin
		we    = 1'b0;
		waddr = cur_idx;
		wdata = data_q;
		raddr = cur_idx;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = (ptr_q == '0) ? CURSOR_BIT : 8'h00;
			end
			ST_IDLE: begin
				raddr = ADDR_W'(head.addr);
			end
			ST_UNMARK_WR: begin
				we    = 1'b1;
				wdata = rdata & ~CURSOR_BIT;
			end
			ST_MARK_WR: begin
				we    = 1'b1;
				wdata = rdata | CURSOR_BIT;
			end
			ST_PUT: begin
				we    = 1'b1;
				wdata = (col_q == LAST_COL) ? (data_q | CURSOR_BIT) : data_q;
			end
			ST_SCR_COPY: begin
				// read one cell ahead while the previous one lands a line up
				raddr = ptr_q;
				we    = rv_q;
				waddr = dst_q;
				wdata = rdata;
			end
			ST_SCR_DRAIN: begin
				we    = rv_q;
				waddr = dst_q;
				wdata = rdata;
			end
			ST_SCR_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = 8'h00;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			defer_q     <= 1'b0;
			kind_q      <= KIND_IGNORE;
			data_q      <= '0;
			cell_q      <= '0;
			ptr_q       <= '0;
			last_q      <= '0;
			dst_q       <= '0;
			rv_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_wrap_q  <= 1'b0;
			out_cell_q  <= '0;
		end else begin
			rv_q <= (state_q == ST_SCR_COPY);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cell_q <= 8'h00;
					if (head_valid) begin
						kind_q <= head.kind;
						data_q <= head.data;
						case (head.kind)
							KIND_READ: state_q <= ST_READ;
							KIND_PRINT: state_q <= defer_q ? ST_UNMARK_RD : ST_PUT;
							KIND_BS: begin
								defer_q <= 1'b0;
								state_q <= (col_q != '0) ? ST_UNMARK_RD : ST_RESULT;
							end
							KIND_TAB: state_q <= ST_UNMARK_RD;
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_READ: begin
					cell_q  <= rdata;
					state_q <= ST_RESULT;
				end
				ST_UNMARK_RD: begin
					state_q <= ST_UNMARK_WR;
				end
				ST_UNMARK_WR: begin
					case (kind_q)
						KIND_BS: begin
							col_q   <= col_q - 1'b1;
							state_q <= ST_MARK_RD;
						end
						KIND_TAB: begin
							col_q   <= tab_col;
							state_q <= ST_MARK_RD;
						end
						default: begin
							// deferred wrap: next line, or scroll from the last line
							if (row_q == LAST_ROW) begin
								state_q <= ST_SCR_SET;
							end else begin
								row_q   <= row_q + 1'b1;
								col_q   <= '0;
								state_q <= ST_PUT;
							end
						end
					endcase
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					state_q <= ST_RESULT;
				end
				ST_PUT: begin
					if (col_q == LAST_COL) begin
						defer_q <= 1'b1;
						state_q <= ST_RESULT;
					end else begin
						col_q   <= col_q + 1'b1;
						defer_q <= 1'b0;
						state_q <= ST_MARK_RD;
					end
				end
				ST_SCR_SET: begin
					cnt_q <= '0;
					if (bot_c > top_c) begin
						ptr_q   <= ADDR_W'(top_c) * COLS_A + COLS_A;
						last_q  <= bot_base + COLS_A - 1'b1;
						state_q <= ST_SCR_COPY;
					end else begin
						ptr_q   <= bot_base;
						state_q <= ST_SCR_CLEAR;
					end
				end
				ST_SCR_COPY: begin
					dst_q <= ptr_q - COLS_A;
					if (ptr_q == last_q) begin
						state_q <= ST_SCR_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_SCR_DRAIN: begin
					ptr_q   <= bot_base;
					cnt_q   <= '0;
					state_q <= ST_SCR_CLEAR;
				end
				ST_SCR_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_COL) begin
						col_q   <= '0;
						state_q <= ST_PUT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_row_q   <= row_q;
						out_col_q   <= col_q;
						out_wrap_q  <= defer_q;
						out_cell_q  <= cell_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty        = !out_valid_q;
	assign cursor_row   = ROW_PORT_W'(out_row_q);
	assign cursor_col   = COL_PORT_W'(out_col_q);
	assign wrap_pending = out_wrap_q;
	assign cell_value   = out_cell_q;

endmodule

`default_nettype wire
